### sv/timer_compare_uart_8n1_defines.svh
// Assertion macros for the tick-timed 8N1 UART.
// Included by the top level; needs no other file.
`ifndef TIMER_COMPARE_UART_8N1_DEFINES_SVH
`define TIMER_COMPARE_UART_8N1_DEFINES_SVH
`ifndef ASSERT_OFF
// Implication property checked on every rising clock edge outside reset.
`define TCU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never be true outside reset.
`define TCU_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define TCU_ASSERT(label, clk, rst, prop, msg)
`define TCU_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

### sv/tcu_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register indexes and status types of the 8N1 UART.
// Used by the transmitter, the receiver and the top level; no dependencies.
package tcu_pkg;

   // Frame format: start, data bits LSB first, stop.
   localparam int DATA_BITS  = 8;
   localparam int FRAME_BITS = DATA_BITS + 2;

   // Default width of the tick counters.
   localparam int TICK_COUNTER_BITS = 16;

   // Width of the intermediate used to saturate periods into a counter.
   localparam int CLAMP_W = 33;

   // Configuration registers.
   localparam int BIT_PERIOD_W      = 16;
   localparam int HALF_BIT_PERIOD_W = 15;
   localparam logic [BIT_PERIOD_W-1:0]      BIT_PERIOD_RESET      = 16'd104;
   localparam logic [HALF_BIT_PERIOD_W-1:0] HALF_BIT_PERIOD_RESET = 15'd52;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_PERIOD      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_BIT_PERIOD = 2'd1;

   // Transmitter state as seen on the result channel.
   typedef struct packed {
      logic line;
      logic busy;
   } tcu_tx_status_type;

   // Receiver result of the most recent tick.
   typedef struct packed {
      logic                 valid;
      logic [DATA_BITS-1:0] data;
   } tcu_rx_result_type;

endpackage

### sv/tcu_tx.sv
`timescale 1ns / 1ps
// Transmitter of the 8N1 UART: frame shifter, bit counter and tick counter.
// Depends on tcu_pkg.
module tcu_tx
   import tcu_pkg::*;
#(
   parameter int TICK_BITS = TICK_COUNTER_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    tx_load,
   input  logic [DATA_BITS-1:0]    tx_data,
   input  logic [BIT_PERIOD_W-1:0] bit_period,
   output tcu_tx_status_type       status
);

   localparam int TXB = $clog2(FRAME_BITS + 1);
   localparam logic [CLAMP_W-1:0] CNT_MAX_WIDE = (CLAMP_W'(1) << TICK_BITS) - CLAMP_W'(1);

   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic [TXB-1:0]        bits_ff, bits_in;
   logic [TICK_BITS-1:0]  cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  line_ff, line_in;
   logic [CLAMP_W-1:0]    bp_wide;
   logic [TICK_BITS-1:0]  bp_clamp;

   // Saturate the bit period into the tick counter.
   assign bp_wide  = CLAMP_W'(bit_period);
   assign bp_clamp = (bp_wide > CNT_MAX_WIDE) ? TICK_BITS'(CNT_MAX_WIDE) : TICK_BITS'(bp_wide);

   // Next state for one tick.
   always_comb begin
      shift_in = shift_ff;
      bits_in  = bits_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      line_in  = line_ff;
      if (run_ff) begin
         if (cnt_ff <= TICK_BITS'(1)) begin
            line_in  = shift_ff[0];
            shift_in = {1'b0, shift_ff[FRAME_BITS-1:1]};
            bits_in  = bits_ff - TXB'(1);
            if (bits_in == '0) begin
               run_in  = 1'b0;
               bits_in = TXB'(FRAME_BITS);
            end else begin
               cnt_in = bp_clamp;
            end
         end else begin
            cnt_in = cnt_ff - TICK_BITS'(1);
         end
      end else if (tx_load) begin
         shift_in = {1'b1, tx_data, 1'b0};
         bits_in  = TXB'(FRAME_BITS);
         cnt_in   = bp_clamp;
         run_in   = 1'b1;
      end
   end

   // State advances once per accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         bits_ff  <= TXB'(FRAME_BITS);
         cnt_ff   <= '0;
         run_ff   <= 1'b0;
         line_ff  <= 1'b1;
      end else if (step) begin
         shift_ff <= shift_in;
         bits_ff  <= bits_in;
         cnt_ff   <= cnt_in;
         run_ff   <= run_in;
         line_ff  <= line_in;
      end
   end

   assign status.line = line_ff;
   assign status.busy = run_ff;

endmodule

### sv/tcu_rx.sv
`timescale 1ns / 1ps
// Receiver of the 8N1 UART: start-edge hunter, sample timer and data shifter.
// Depends on tcu_pkg.
module tcu_rx
   import tcu_pkg::*;
#(
   parameter int TICK_BITS = TICK_COUNTER_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic                         rxd_level,
   input  logic [BIT_PERIOD_W-1:0]      bit_period,
   input  logic [HALF_BIT_PERIOD_W-1:0] half_bit_period,
   output tcu_rx_result_type            result
);

   localparam int RXB = $clog2(DATA_BITS + 1);
   localparam logic [CLAMP_W-1:0] CNT_MAX_WIDE = (CLAMP_W'(1) << TICK_BITS) - CLAMP_W'(1);

   logic                 hunt_ff, hunt_in;
   logic [TICK_BITS-1:0] cnt_ff, cnt_in;
   logic [DATA_BITS-1:0] shift_ff, shift_in;
   logic [RXB-1:0]       bits_ff, bits_in;
   logic                 prev_ff;
   logic                 valid_ff, valid_in;
   logic [CLAMP_W-1:0]   bp_wide, first_wide;
   logic [TICK_BITS-1:0] bp_clamp, first_clamp;

   // Saturate the sample intervals into the tick counter.
   assign bp_wide     = CLAMP_W'(bit_period);
   assign first_wide  = CLAMP_W'(bit_period) + CLAMP_W'(half_bit_period);
   assign bp_clamp    = (bp_wide > CNT_MAX_WIDE) ? TICK_BITS'(CNT_MAX_WIDE)
                                                 : TICK_BITS'(bp_wide);
   assign first_clamp = (first_wide > CNT_MAX_WIDE) ? TICK_BITS'(CNT_MAX_WIDE)
                                                    : TICK_BITS'(first_wide);

   // Next state for one tick.
   always_comb begin
      hunt_in  = hunt_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      bits_in  = bits_ff;
      valid_in = 1'b0;
      if (hunt_ff) begin
         if (prev_ff && !rxd_level) begin
            hunt_in = 1'b0;
            bits_in = RXB'(DATA_BITS);
            cnt_in  = first_clamp;
         end
      end else if (cnt_ff <= TICK_BITS'(1)) begin
         shift_in = {rxd_level, shift_ff[DATA_BITS-1:1]};
         bits_in  = bits_ff - RXB'(1);
         if (bits_in == '0) begin
            valid_in = 1'b1;
            bits_in  = RXB'(DATA_BITS);
            hunt_in  = 1'b1;
         end else begin
            cnt_in = bp_clamp;
         end
      end else begin
         cnt_in = cnt_ff - TICK_BITS'(1);
      end
   end

   // State advances once per accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         hunt_ff  <= 1'b1;
         cnt_ff   <= '0;
         shift_ff <= '0;
         bits_ff  <= RXB'(DATA_BITS);
         prev_ff  <= 1'b1;
         valid_ff <= 1'b0;
      end else if (step) begin
         hunt_ff  <= hunt_in;
         cnt_ff   <= cnt_in;
         shift_ff <= shift_in;
         bits_ff  <= bits_in;
         prev_ff  <= rxd_level;
         valid_ff <= valid_in;
      end
   end

   // The data word reads as zero on ticks that complete nothing.
   assign result.valid = valid_ff;
   assign result.data  = valid_ff ? shift_ff : '0;

endmodule

### sv/timer_compare_uart_8n1.sv
`timescale 1ns / 1ps
// Tick-timed full-duplex 8N1 UART; one item is one timer tick.
// A result leaves through the input register, then the transmitter and receiver state, which
// doubles as the result register. Throughput: one item per cycle, set by the combinational
// next-state logic, while the result channel does not stall.
// Reset (synchronous, active high) idles both directions and loads the default periods.
// Depends on tcu_pkg, tcu_tx, tcu_rx and timer_compare_uart_8n1_defines.svh.
`include "timer_compare_uart_8n1_defines.svh"
module timer_compare_uart_8n1
   import tcu_pkg::*;
#(
   parameter int TICK_BITS = TICK_COUNTER_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   // Input channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_rxd_level,
   input  logic                    req_tx_load,
   input  logic [DATA_BITS-1:0]    req_tx_byte,
   // Result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_txd_level,
   output logic                    rsp_tx_busy,
   output logic                    rsp_rx_valid,
   output logic [DATA_BITS-1:0]    rsp_rx_byte,
   // Configuration port
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [BIT_PERIOD_W-1:0] csr_wdata
);

   logic [BIT_PERIOD_W-1:0]      bit_period_ff;
   logic [HALF_BIT_PERIOD_W-1:0] half_bit_period_ff;

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_rxd_ff;
   logic                 s1_load_ff;
   logic [DATA_BITS-1:0] s1_byte_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_ready;
   logic                 step;
   logic                 req_accept;

   tcu_tx_status_type tx_status;
   tcu_rx_result_type rx_result;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff      <= BIT_PERIOD_RESET;
         half_bit_period_ff <= HALF_BIT_PERIOD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BIT_PERIOD:      bit_period_ff      <= csr_wdata;
            CSR_HALF_BIT_PERIOD: half_bit_period_ff <= csr_wdata[HALF_BIT_PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: the input register advances into the state when the result slot frees.
   assign out_ready    = !rsp_valid_ff || !rsp_stall;
   assign step         = s1_valid_ff && out_ready;
   assign req_stall    = s1_valid_ff && !out_ready;
   assign req_accept   = req_valid && !req_stall;
   assign s1_valid_in  = req_accept ? 1'b1 : (step ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = step ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_rxd_ff  <= req_rxd_level;
         s1_load_ff <= req_tx_load;
         s1_byte_ff <= req_tx_byte;
      end
   end

   tcu_tx #(
      .TICK_BITS (TICK_BITS)
   ) u_tx (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .tx_load    (s1_load_ff),
      .tx_data    (s1_byte_ff),
      .bit_period (bit_period_ff),
      .status     (tx_status)
   );

   tcu_rx #(
      .TICK_BITS (TICK_BITS)
   ) u_rx (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .rxd_level       (s1_rxd_ff),
      .bit_period      (bit_period_ff),
      .half_bit_period (half_bit_period_ff),
      .result          (rx_result)
   );

   // Result channel reads the state registers directly.
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_txd_level = tx_status.line;
   assign rsp_tx_busy   = tx_status.busy;
   assign rsp_rx_valid  = rx_result.valid;
   assign rsp_rx_byte   = rx_result.data;

   // A load on an idle transmitter starts a frame.
   `TCU_ASSERT(a_tx_starts, clock, reset, (step && !tx_status.busy && s1_load_ff |=> rsp_tx_busy), "tx load while idle did not start a frame")
   // A received word is followed by a tick without one.
   `TCU_ASSERT(a_rx_pulse, clock, reset, (step && rsp_rx_valid |=> !rsp_rx_valid), "rx valid lasted more than one tick")
   // The frame ends on the stop bit, a mark.
   `TCU_ASSERT(a_tx_stop_mark, clock, reset, ($fell(rsp_tx_busy) |-> rsp_txd_level), "busy cleared without a stop bit on the line")
   // Input stalls only while an item is held.
   `TCU_ASSERT_NEVER(a_stall_empty, clock, reset, (req_stall && !s1_valid_ff), "input stalled with an empty input register")

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the tick-timed 8N1 UART (timer_compare_uart_8n1).
// Each item is one timer tick; a tick-level model predicts every result item.
// Depends on tcu_pkg and the RTL of the block.
module testbench;
   import tcu_pkg::*;

   // Spare register indexes that the block must ignore.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;
   localparam longint unsigned COUNT_MAX = (64'd1 << TICK_COUNTER_BITS) - 1;

   typedef struct packed {
      logic                 rxd;
      logic                 load;
      logic [DATA_BITS-1:0] data;
   } tick_type;

   typedef struct packed {
      logic                 txd;
      logic                 busy;
      logic                 rx_valid;
      logic [DATA_BITS-1:0] rx_byte;
   } line_status_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_rxd_level = 1'b1;
   logic                    req_tx_load = 1'b0;
   logic [DATA_BITS-1:0]    req_tx_byte = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_txd_level;
   logic                    rsp_tx_busy;
   logic                    rsp_rx_valid;
   logic [DATA_BITS-1:0]    rsp_rx_byte;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = CSR_BIT_PERIOD;
   logic [BIT_PERIOD_W-1:0] csr_wdata = '0;

   timer_compare_uart_8n1 dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rxd_level (req_rxd_level),
      .req_tx_load   (req_tx_load),
      .req_tx_byte   (req_tx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_txd_level (rsp_txd_level),
      .rsp_tx_busy   (rsp_tx_busy),
      .rsp_rx_valid  (rsp_rx_valid),
      .rsp_rx_byte   (rsp_rx_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #6 clock = ~clock;

   // Ticks waiting to be sent and line states still owed by the block.
   tick_type        pending_ticks[$];
   line_status_type line_status_due[$];

   // Model configuration and state.
   logic [BIT_PERIOD_W-1:0]      period_ticks = BIT_PERIOD_RESET;
   logic [HALF_BIT_PERIOD_W-1:0] half_ticks   = HALF_BIT_PERIOD_RESET;
   logic [FRAME_BITS-1:0]        tx_shift     = '0;
   int unsigned                  tx_left      = FRAME_BITS;
   longint unsigned              tx_count     = 0;
   bit                           tx_on        = 1'b0;
   logic                         tx_txd       = 1'b1;
   bit                           rx_hunt      = 1'b1;
   longint unsigned              rx_count     = 0;
   logic [DATA_BITS-1:0]         rx_shift     = '0;
   int unsigned                  rx_left      = DATA_BITS;
   logic                         rx_prev      = 1'b1;

   // Bookkeeping.
   int  error_count     = 0;
   int  ticks_sent      = 0;
   int  results_checked = 0;
   int  frames_started  = 0;
   int  bytes_seen      = 0;
   bit  req_taken       = 1'b0;
   bit  no_idle         = 1'b0;
   bit  pressure_armed  = 1'b0;
   bit  pressure_done   = 1'b0;
   int  send_gap        = 0;
   int  send_odds       = 0;
   int  send_cycle      = 0;
   int  hold_left       = 0;
   int  stall_odds      = 0;
   int  stall_cycle     = 0;
   tick_type        next_tick;
   tick_type        seen_tick;
   line_status_type got_status;
   line_status_type want_status;

   // Prints one mismatch line and counts it.
   task automatic flag_error(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("MISMATCH at result %0d, %s: got %0h, expected %0h", results_checked, what, got,
               want);
      error_count++;
   endtask

   // Idle rate for the next stretch: 0 means no idling at all.
   function automatic int pick_odds();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 3;
         2: return 8;
         default: return 20;
      endcase
   endfunction

   function automatic bit roll(input int odds);
      return odds != 0 && $urandom_range(1, odds) == 1;
   endfunction

   // Advances the UART model by one tick and queues the line state it leaves.
   task automatic uart_tick(input tick_type t);
      line_status_type r;
      longint unsigned span;
      r = '0;
      // Transmitter: busy is judged at the start of the tick.
      if (tx_on) begin
         if (tx_count <= 1) begin
            tx_txd   = tx_shift[0];
            tx_shift = tx_shift >> 1;
            tx_left  = tx_left - 1;
            if (tx_left == 0) begin
               tx_on   = 1'b0;
               tx_left = FRAME_BITS;
            end else begin
               tx_count = 64'(period_ticks);
            end
         end else begin
            tx_count--;
         end
      end else if (t.load) begin
         tx_shift = {1'b1, t.data, 1'b0};
         tx_left  = FRAME_BITS;
         tx_count = 64'(period_ticks);
         tx_on    = 1'b1;
         frames_started++;
      end
      // Receiver: a falling edge while hunting starts a word.
      if (rx_hunt) begin
         if (rx_prev && !t.rxd) begin
            rx_hunt  = 1'b0;
            rx_left  = DATA_BITS;
            span     = 64'(period_ticks) + 64'(half_ticks);
            rx_count = (span > COUNT_MAX) ? COUNT_MAX : span;
         end
      end else if (rx_count <= 1) begin
         rx_shift = {t.rxd, rx_shift[DATA_BITS-1:1]};
         rx_left  = rx_left - 1;
         if (rx_left == 0) begin
            r.rx_valid = 1'b1;
            r.rx_byte  = rx_shift;
            rx_left    = DATA_BITS;
            rx_hunt    = 1'b1;
            bytes_seen++;
         end else begin
            rx_count = 64'(period_ticks);
         end
      end else begin
         rx_count--;
      end
      rx_prev = t.rxd;
      r.txd   = tx_txd;
      r.busy  = tx_on;
      line_status_due.push_back(r);
   endtask

   // Driver: presents queued ticks, with bursts of idle cycles between them.
   always @(negedge clock) begin
      send_cycle++;
      if (send_cycle % 128 == 0) begin
         send_odds = pick_odds();
      end
      if (!reset && !(req_valid && !req_taken)) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (pending_ticks.size() > 0) begin
            next_tick = pending_ticks.pop_front();
            req_valid     <= 1'b1;
            req_rxd_level <= next_tick.rxd;
            req_tx_load   <= next_tick.load;
            req_tx_byte   <= next_tick.data;
            if (!no_idle && roll(send_odds)) begin
               send_gap = $urandom_range(1, 16);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver side: random stall bursts, plus one long hold-off to back up the block.
   always @(negedge clock) begin
      stall_cycle++;
      if (stall_cycle % 128 == 0) begin
         stall_odds = pick_odds();
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (pressure_armed && !pressure_done) begin
         rsp_stall <= 1'b1;
         hold_left = 79;
         pressure_done = 1'b1;
      end else if (no_idle) begin
         rsp_stall <= 1'b0;
      end else if (roll(stall_odds)) begin
         rsp_stall <= 1'b1;
         hold_left = $urandom_range(0, 15);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: predicts from each accepted item and checks each accepted result.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            seen_tick = '{req_rxd_level, req_tx_load, req_tx_byte};
            uart_tick(seen_tick);
            ticks_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            got_status = '{rsp_txd_level, rsp_tx_busy, rsp_rx_valid, rsp_rx_byte};
            if (line_status_due.size() == 0) begin
               flag_error("result with nothing expected", 32'(got_status), 32'd0);
            end else begin
               want_status = line_status_due.pop_front();
               if (got_status.txd !== want_status.txd)
                  flag_error("txd_level", 32'(got_status.txd), 32'(want_status.txd));
               if (got_status.busy !== want_status.busy)
                  flag_error("tx_busy", 32'(got_status.busy), 32'(want_status.busy));
               if (got_status.rx_valid !== want_status.rx_valid)
                  flag_error("rx_valid", 32'(got_status.rx_valid), 32'(want_status.rx_valid));
               if (got_status.rx_byte !== want_status.rx_byte)
                  flag_error("rx_byte", 32'(got_status.rx_byte), 32'(want_status.rx_byte));
            end
         end
      end
   end

   task automatic push_tick(input logic rxd, input logic load, input logic [DATA_BITS-1:0] data);
      pending_ticks.push_back('{rxd, load, data});
   endtask

   // Holds the receive line at one level for n ticks, with random transmit requests.
   task automatic push_line(input logic rxd, input int n);
      int k;
      for (k = 0; k < n; k++) begin
         push_tick(rxd, $urandom_range(0, 5) == 0, DATA_BITS'($urandom));
      end
   endtask

   // A well-formed 8N1 frame on the receive line, bp ticks per bit.
   task automatic push_frame(input int bp, input logic [DATA_BITS-1:0] data, input int lead);
      int k;
      push_line(1'b1, lead);
      push_line(1'b0, bp);
      for (k = 0; k < DATA_BITS; k++) begin
         push_line(data[k], bp);
      end
      push_line(1'b1, bp);
   endtask

   // Random line activity with runs of uneven length.
   task automatic push_noise(input int n);
      int   k;
      logic lvl;
      lvl = 1'b1;
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 2) == 0) begin
            lvl = ~lvl;
         end
         push_line(lvl, 1);
      end
   endtask

   // Waits until every tick is sent and every result has come back.
   task automatic drain();
      while (pending_ticks.size() != 0 || req_valid || line_status_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Feeds a quiet line until both directions of the model are idle again.
   task automatic settle();
      int k;
      while (tx_on || !rx_hunt) begin
         @(posedge clock);
         for (k = 0; k < 12 * (period_ticks + 1) + half_ticks + 4; k++) begin
            push_tick(1'b1, 1'b0, '0);
         end
         drain();
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [BIT_PERIOD_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      case (idx)
         CSR_BIT_PERIOD:      period_ticks = value;
         CSR_HALF_BIT_PERIOD: half_ticks = value[HALF_BIT_PERIOD_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stimulus: directed corners first, then random phases at several bit periods.
   initial begin : stimulus
      int bp;
      int phase;
      int start_count;
      int waited;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset periods: a frame each way and a request while busy. The periods
      // then shrink while both frames are still running.
      @(posedge clock);
      push_tick(1'b1, 1'b1, 8'hA5);
      push_tick(1'b1, 1'b1, 8'h5A);
      push_tick(1'b0, 1'b0, 8'h00);
      push_tick(1'b1, 1'b0, 8'h00);
      drain();

      // Zero-tick periods: every event fires on every tick.
      write_csr(CSR_BIT_PERIOD, 16'd0);
      write_csr(CSR_HALF_BIT_PERIOD, 16'd0);
      settle();
      @(posedge clock);
      push_tick(1'b1, 1'b1, 8'h00);
      push_tick(1'b1, 1'b1, 8'hFF);
      push_tick(1'b0, 1'b0, 8'h00);
      push_tick(1'b1, 1'b0, 8'h00);
      push_tick(1'b1, 1'b0, 8'h00);
      push_tick(1'b0, 1'b0, 8'h00);
      push_tick(1'b0, 1'b0, 8'h00);
      push_tick(1'b1, 1'b0, 8'h00);
      push_tick(1'b0, 1'b0, 8'h00);
      push_tick(1'b1, 1'b0, 8'h00);
      // Last sample and busy clearing on the same tick; this request is dropped.
      push_tick(1'b1, 1'b1, 8'h3C);
      // Request right after busy clears, and an edge as soon as hunting resumes.
      push_tick(1'b0, 1'b1, 8'hFF);
      push_noise(10);
      drain();
      settle();

      // One-tick periods; the top bit of the half period write is dropped.
      write_csr(CSR_BIT_PERIOD, 16'd1);
      write_csr(CSR_HALF_BIT_PERIOD, 16'h8001);
      @(posedge clock);
      push_frame(1, 8'h96, 2);
      push_noise(24);
      drain();
      settle();

      // Random phases: mostly clean frames, some noise and broken frames.
      for (phase = 0; phase < 5; phase++) begin
         bp = $urandom_range(2, 5);
         write_csr(CSR_BIT_PERIOD, BIT_PERIOD_W'(bp));
         write_csr(CSR_HALF_BIT_PERIOD, BIT_PERIOD_W'($urandom_range(0, bp)));
         if (phase == 1) begin
            write_csr(CSR_SPARE_2, BIT_PERIOD_W'($urandom));
            write_csr(CSR_SPARE_3, BIT_PERIOD_W'($urandom));
         end
         @(posedge clock);
         pressure_armed = 1'b1;
         if (phase == 3) begin
            no_idle = 1'b1;
         end
         start_count = pending_ticks.size();
         if (phase == 0) begin
            push_frame(bp, 8'h00, 1);
            push_frame(bp, 8'hFF, 0);
         end
         while (pending_ticks.size() - start_count < 60) begin
            case ($urandom_range(0, 9))
               0: push_noise($urandom_range(4, 30));
               1: begin
                  push_line(1'b1, 2);
                  push_line(1'b0, $urandom_range(1, bp));
                  push_noise($urandom_range(1, 6 * bp));
               end
               default: push_frame(bp, DATA_BITS'($urandom), $urandom_range(0, 6));
            endcase
         end
         drain();
         settle();
      end

      // Longest periods; their sum saturates the counter. No settling after this.
      write_csr(CSR_BIT_PERIOD, 16'hFFFF);
      write_csr(CSR_HALF_BIT_PERIOD, 16'hFFFF);
      @(posedge clock);
      push_tick(1'b1, 1'b1, DATA_BITS'($urandom));
      push_tick(1'b0, 1'b0, DATA_BITS'($urandom));
      push_noise(150);

      waited = 0;
      while ((pending_ticks.size() != 0 || req_valid || line_status_due.size() != 0)
             && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (line_status_due.size() != 0) begin
         flag_error("results never delivered", 32'(line_status_due.size()), 32'd0);
      end

      $display("Sent %0d ticks and checked %0d results: %0d frames transmitted, %0d bytes received.",
               ticks_sent, results_checked, frames_started, bytes_seen);
      $display("Bit periods ran from zero ticks up to the counter limit, with stalls on both sides.");
      if (error_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #10_000_000;
      $display("Timeout: the run did not complete.");
      $display("testbench NOT OK");
      $finish;
   end

endmodule
